FILE: rtl/htm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htm_pkg
// Shared types and constants for the hit to trigger primitive merge block.
// ----------------------------------------------------------------------------
package htm_pkg;

  // burst storage sizing
  localparam int MAX_HITS  = 32;
  localparam int HIT_CNT_W = $clog2(MAX_HITS + 1);
  localparam int HIT_IDX_W = $clog2(MAX_HITS);

  // field widths
  localparam int ID_W   = 16;
  localparam int CHAN_W = 32;
  localparam int TIME_W = 32;
  localparam int TICK_W = 32;
  localparam int MULT_W = 6;

  localparam logic [MULT_W-1:0] MULT_MAX = 6'd63;

  // tick arithmetic: tick = ref + floor((800 + t - tmin) / 400)
  // 400 = 16 * 25, so shift by four and then divide by 25 with a reciprocal
  localparam int REL_W     = TIME_W + 1;
  localparam logic [REL_W-1:0] OFFSET_SIXTEENTHS = 33'd800;
  localparam int SCALED_W  = REL_W - 4;
  localparam int RECIP_W   = 30;
  localparam int RECIP_SHIFT = 34;
  // ceil(2^34 / 25), exact for every dividend below 2^30
  localparam logic [RECIP_W-1:0] TICK_RECIP = 30'd687194768;
  localparam int PROD_W    = SCALED_W + RECIP_W;
  localparam int QUOT_W    = PROD_W - RECIP_SHIFT;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] start;
  } hit_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CHAN_W-1:0] chan;
    logic [TICK_W-1:0] tick;
    logic [MULT_W-1:0] mult;
  } prim_entry_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_HIT_RD,
    ST_HIT_DATA,
    ST_SCAN,
    ST_NEW,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_HOLD
  } state_t;

endpackage

FILE: rtl/htm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htm_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module htm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/htm_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htm_tick
// Three stage pipeline that turns a hit start time into a primitive tick.
// ----------------------------------------------------------------------------
module htm_tick (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [htm_pkg::TIME_W-1:0]  start_time,
  input  logic [htm_pkg::TIME_W-1:0]  earliest_time,
  input  logic [htm_pkg::TICK_W-1:0]  reference,
  output logic                        done,
  output logic [htm_pkg::TICK_W-1:0]  tick
);

  import htm_pkg::*;

  logic                v1;
  logic                v2;
  logic [REL_W-1:0]    rel;
  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]   prod;

  // relative time plus offset, never negative since tmin is the minimum
  assign rel = OFFSET_SIXTEENTHS + {1'b0, start_time} - {1'b0, earliest_time};

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // divide by 16, then by 25 through the reciprocal, then add the base tick
  always_ff @(posedge clk) begin
    scaled <= rel[REL_W-1:4];
    prod   <= PROD_W'(scaled) * PROD_W'(TICK_RECIP);
    tick   <= reference + TICK_W'(prod[PROD_W-1:RECIP_SHIFT]);
  end

endmodule

FILE: rtl/hit_to_trigger_primitive_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_to_trigger_primitive_merge
// Collects a burst of hits, merges them by channel into trigger primitives
// and streams the primitives out in order of first appearance.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  in        in_valid/in_ready    hit_number, channel_key, start_time, last_hit
//  out       out_valid/out_ready  prim_hit_number, prim_channel, prim_tick,
//                                 multiplicity, last_prim
//  cfg       cfg_wr_en            cfg_wr_data (clocktick reference)
//
//  Hits are taken one per cycle while loading. On the last hit the merge
//  runs: per stored hit the hit store is read, then the primitive table is
//  scanned one entry per cycle until a channel matches (a new primitive
//  waits for the tick pipeline, then gets its write), then the hit index
//  advances; each primitive then goes out through the table read port and
//  the output register and is held through any stall on out_ready.
//  The primitive table read port sets the scan rate of one entry a cycle.
//  Reset clears counters, the tick reference and the earliest time; the stores need no clearing.
//  No hit is taken from the end of the last hit until the last primitive's
//  transfer.
// ----------------------------------------------------------------------------
module hit_to_trigger_primitive_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [htm_pkg::TICK_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [htm_pkg::ID_W-1:0]    hit_number,
  input  logic [htm_pkg::CHAN_W-1:0]  channel_key,
  input  logic [htm_pkg::TIME_W-1:0]  start_time,
  input  logic                        last_hit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [htm_pkg::ID_W-1:0]    prim_hit_number,
  output logic [htm_pkg::CHAN_W-1:0]  prim_channel,
  output logic [htm_pkg::TICK_W-1:0]  prim_tick,
  output logic [htm_pkg::MULT_W-1:0]  multiplicity,
  output logic                        last_prim
);

  import htm_pkg::*;

  state_t state;
  state_t state_next;

  logic [TICK_W-1:0]    clocktick_reference;
  logic [HIT_CNT_W-1:0] hit_count;
  logic [HIT_CNT_W-1:0] prim_count;
  logic [TIME_W-1:0]    earliest_time;
  logic [HIT_IDX_W-1:0] hit_idx;
  logic [HIT_IDX_W-1:0] scan_idx;
  logic [HIT_IDX_W-1:0] out_idx;
  logic                 tick_ready;
  prim_entry_t          out_entry;
  logic                 out_last;

  // memory ports
  logic                 hit_we;
  logic [HIT_IDX_W-1:0] hit_waddr;
  hit_entry_t           hit_wdata;
  logic                 hit_re;
  hit_entry_t           hit_rdata;
  logic                 prim_we;
  logic [HIT_IDX_W-1:0] prim_waddr;
  prim_entry_t          prim_wdata;
  logic                 prim_re;
  logic [HIT_IDX_W-1:0] prim_raddr;
  prim_entry_t          prim_rdata;

  logic                 tick_start;
  logic                 tick_done;
  logic [TICK_W-1:0]    tick_value;

  logic                 in_xfer;
  logic                 store_room;
  logic                 prim_room;
  logic                 chan_match;
  logic                 scan_last;
  logic                 hit_last;
  logic                 out_last_c;

  // status terms
  assign in_xfer    = in_valid && in_ready;
  assign store_room = (hit_count < HIT_CNT_W'(MAX_HITS));
  assign prim_room  = (prim_count < HIT_CNT_W'(MAX_HITS));
  assign chan_match = (prim_rdata.chan == hit_rdata.chan);
  assign scan_last  = ({1'b0, scan_idx} + 1'b1 == prim_count);
  assign hit_last   = ({1'b0, hit_idx} + 1'b1 == hit_count);
  assign out_last_c = ({1'b0, out_idx} + 1'b1 == prim_count);

  // hit store
  htm_ram #(
    .WIDTH($bits(hit_entry_t)),
    .DEPTH(MAX_HITS)
  ) u_hit_store (
    .clk     (clk),
    .wr_en   (hit_we),
    .wr_addr (hit_waddr),
    .wr_data (hit_wdata),
    .rd_en   (hit_re),
    .rd_addr (hit_idx),
    .rd_data (hit_rdata)
  );

  // primitive table
  htm_ram #(
    .WIDTH($bits(prim_entry_t)),
    .DEPTH(MAX_HITS)
  ) u_prim_table (
    .clk     (clk),
    .wr_en   (prim_we),
    .wr_addr (prim_waddr),
    .wr_data (prim_wdata),
    .rd_en   (prim_re),
    .rd_addr (prim_raddr),
    .rd_data (prim_rdata)
  );

  // tick computation for the current hit
  htm_tick u_tick (
    .clk           (clk),
    .rst           (rst),
    .start         (tick_start),
    .start_time    (hit_rdata.start),
    .earliest_time (earliest_time),
    .reference     (clocktick_reference),
    .done          (tick_done),
    .tick          (tick_value)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer && last_hit) begin
          state_next = ST_HIT_RD;
        end
      end
      ST_HIT_RD:   state_next = ST_HIT_DATA;
      ST_HIT_DATA: state_next = (prim_count == '0) ? ST_NEW : ST_SCAN;
      ST_SCAN: begin
        if (chan_match) begin
          state_next = ST_NEXT;
        end else if (scan_last) begin
          state_next = ST_NEW;
        end
      end
      ST_NEW: begin
        if (tick_ready) begin
          state_next = ST_NEXT;
        end
      end
      ST_NEXT:     state_next = hit_last ? ST_OUT_RD : ST_HIT_RD;
      ST_OUT_RD:   state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (out_ready) begin
          state_next = out_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    hit_we     = 1'b0;
    hit_waddr  = hit_count[HIT_IDX_W-1:0];
    hit_wdata  = '{id: hit_number, chan: channel_key, start: start_time};
    hit_re     = 1'b0;
    prim_re    = 1'b0;
    prim_raddr = '0;
    prim_we    = 1'b0;
    prim_waddr = scan_idx;
    prim_wdata = prim_rdata;
    tick_start = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        hit_we   = in_valid && store_room;
      end
      ST_HIT_RD: begin
        hit_re = 1'b1;
      end
      ST_HIT_DATA: begin
        tick_start = 1'b1;
        prim_re    = (prim_count != '0);
      end
      ST_SCAN: begin
        if (chan_match) begin
          // bump the multiplicity of the matching primitive
          prim_we = 1'b1;
          if (prim_rdata.mult != MULT_MAX) begin
            prim_wdata.mult = prim_rdata.mult + 1'b1;
          end
        end else if (!scan_last) begin
          prim_re    = 1'b1;
          prim_raddr = scan_idx + 1'b1;
        end
      end
      ST_NEW: begin
        // open a primitive for a channel not seen yet
        prim_we    = tick_ready && prim_room;
        prim_waddr = prim_count[HIT_IDX_W-1:0];
        prim_wdata = '{id: hit_rdata.id, chan: hit_rdata.chan, tick: tick_value,
                       mult: MULT_W'(1)};
      end
      ST_OUT_RD: begin
        prim_re    = 1'b1;
        prim_raddr = out_idx;
      end
      ST_OUT_HOLD: begin
        out_valid = 1'b1;
      end
      ST_NEXT, ST_OUT_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_LOAD;
      clocktick_reference <= '0;
      hit_count           <= '0;
      prim_count          <= '0;
      earliest_time       <= '1;
      hit_idx             <= '0;
      scan_idx            <= '0;
      out_idx             <= '0;
      tick_ready          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        clocktick_reference <= cfg_wr_data;
      end
      if (tick_start) begin
        tick_ready <= 1'b0;
      end else if (tick_done) begin
        tick_ready <= 1'b1;
      end
      case (state)
        ST_LOAD: begin
          if (in_xfer && store_room) begin
            hit_count <= hit_count + 1'b1;
            if (start_time < earliest_time) begin
              earliest_time <= start_time;
            end
          end
          if (in_xfer && last_hit) begin
            hit_idx <= '0;
          end
        end
        ST_HIT_DATA: scan_idx <= '0;
        ST_SCAN: begin
          if (!chan_match && !scan_last) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_NEW: begin
          if (tick_ready && prim_room) begin
            prim_count <= prim_count + 1'b1;
          end
        end
        ST_NEXT: begin
          if (hit_last) begin
            out_idx <= '0;
          end else begin
            hit_idx <= hit_idx + 1'b1;
          end
        end
        ST_OUT_HOLD: begin
          if (out_ready) begin
            if (out_last) begin
              // burst done, back to the empty state
              hit_count     <= '0;
              prim_count    <= '0;
              earliest_time <= '1;
            end else begin
              out_idx <= out_idx + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_OUT_WAIT) begin
      out_entry <= prim_rdata;
      out_last  <= out_last_c;
    end
  end

  assign prim_hit_number = out_entry.id;
  assign prim_channel    = out_entry.chan;
  assign prim_tick       = out_entry.tick;
  assign multiplicity    = out_entry.mult;
  assign last_prim       = out_last;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a primitive is pending");

  a_prim_le_hits: assert property (@(posedge clk) disable iff (rst)
    prim_count <= hit_count)
    else $error("more primitives than stored hits");

  a_hit_bound: assert property (@(posedge clk) disable iff (rst)
    hit_count <= HIT_CNT_W'(MAX_HITS))
    else $error("hit count beyond store depth");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_prim |=> in_ready)
    else $error("block not ready after the last primitive");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for hit_to_trigger_primitive_merge. Bursts of hits
// go in over a valid/ready channel with random gaps. A predictor tracks the
// stored hits and the earliest start time. It merges each burst by channel
// and queues the primitives it expects. A monitor compares every primitive
// transfer field by field. Directed bursts hit the field extremes, merging,
// tick rounding and wrap, and a full store. Random bursts with random
// reference settings and random stalls on both sides make up the rest.
// ----------------------------------------------------------------------------
module tb_top;
  import htm_pkg::*;

  localparam int  ITEM_TARGET = 370;
  localparam int  IDLE_MAX    = 13;
  localparam int  SETTLE_CYC  = 8;
  localparam time WATCHDOG_NS = 2_000_000;
  localparam int  PRINT_LIMIT = 40;

  // tick = reference + floor((800 + t - tmin) / 400), times in 1/16 ns
  localparam logic [32:0] TICK_OFFSET = 33'd800;
  localparam logic [32:0] TICK_LEN    = 33'd400;

  typedef struct {
    prim_entry_t prim;
    logic        last;
  } prim_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [TICK_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [ID_W-1:0]   hit_number;
  logic [CHAN_W-1:0] channel_key;
  logic [TIME_W-1:0] start_time;
  logic              last_hit;
  logic              out_valid;
  logic              out_ready;
  logic [ID_W-1:0]   prim_hit_number;
  logic [CHAN_W-1:0] prim_channel;
  logic [TICK_W-1:0] prim_tick;
  logic [MULT_W-1:0] multiplicity;
  logic              last_prim;

  // predictor state
  logic [TICK_W-1:0] tick_reference;
  hit_entry_t        burst_hits [MAX_HITS];
  int                burst_count;
  logic [TIME_W-1:0] earliest_start;
  prim_result_t      pending_prims [$];

  // bookkeeping
  int errors;
  int hits_sent;
  int bursts_sent;
  int prims_checked;
  int reference_writes;
  int tx_idle_max;
  int rx_idle_max;

  hit_to_trigger_primitive_merge DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .hit_number      (hit_number),
    .channel_key     (channel_key),
    .start_time      (start_time),
    .last_hit        (last_hit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .prim_hit_number (prim_hit_number),
    .prim_channel    (prim_channel),
    .prim_tick       (prim_tick),
    .multiplicity    (multiplicity),
    .last_prim       (last_prim)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // merge the stored burst by channel, primitives in order of first appearance
  task automatic merge_burst();
    prim_entry_t prims [MAX_HITS];
    int          nprims;
    bit          found;
    logic [32:0] rel;
    prim_result_t res;
    nprims = 0;
    for (int i = 0; i < burst_count; i++) begin
      found = 1'b0;
      for (int j = 0; j < nprims; j++) begin
        if (!found && prims[j].chan == burst_hits[i].chan) begin
          found = 1'b1;
          if (prims[j].mult != MULT_MAX) prims[j].mult = prims[j].mult + 1'b1;
        end
      end
      if (!found) begin
        rel = TICK_OFFSET + {1'b0, burst_hits[i].start} - {1'b0, earliest_start};
        prims[nprims].id   = burst_hits[i].id;
        prims[nprims].chan = burst_hits[i].chan;
        prims[nprims].tick = tick_reference + 32'(rel / TICK_LEN);
        prims[nprims].mult = 6'd1;
        nprims++;
      end
    end
    for (int j = 0; j < nprims; j++) begin
      res.prim = prims[j];
      res.last = (j == nprims - 1);
      pending_prims.push_back(res);
    end
    burst_count    = 0;
    earliest_start = '1;
  endtask

  // predictor: store the hit unless the store is full, merge on the last one
  task automatic load_hit(input hit_entry_t h, input logic last);
    if (burst_count < MAX_HITS) begin
      burst_hits[burst_count] = h;
      if (h.start < earliest_start) earliest_start = h.start;
      burst_count++;
    end
    if (last) begin
      merge_burst();
      bursts_sent++;
    end
  endtask

  // one hit transfer with a random lead-in gap
  task automatic send_hit(input logic [ID_W-1:0] id, input logic [CHAN_W-1:0] chan,
                          input logic [TIME_W-1:0] t, input logic last);
    int         gap;
    hit_entry_t h;
    gap = $urandom_range(0, tx_idle_max);
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    hit_number  = id;
    channel_key = chan;
    start_time  = t;
    last_hit    = last;
    do @(posedge clk); while (!in_ready);
    h.id    = id;
    h.chan  = chan;
    h.start = t;
    hits_sent++;
    load_hit(h, last);
  endtask

  // stop sending and let every expected primitive come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reference(input logic [TICK_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    tick_reference = value;
    reference_writes++;
  endtask

  // random burst: channels from a small pool so that hits merge
  task automatic random_burst(input int len);
    logic [CHAN_W-1:0] pool [8];
    int                pool_size;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] spread;
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] t;
    pool_size = $urandom_range(1, 8);
    foreach (pool[k]) pool[k] = $urandom;
    base = $urandom;
    case ($urandom_range(0, 3))
      0: spread = 32'd400;
      1: spread = 32'd4000;
      2: spread = 32'd200000;
      default: spread = '1;
    endcase
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 7) == 0) chan = $urandom;
      else chan = pool[$urandom_range(0, pool_size - 1)];
      if (spread == '1) t = $urandom;
      else t = base + $urandom_range(0, spread);
      send_hit(16'($urandom), chan, t, n == len - 1);
    end
  endtask

  task automatic pick_idling();
    tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
  endtask

  // single-hit bursts at the field extremes, tick wraps past the reference
  task automatic test_single_hits();
    write_reference(32'hFFFF_FFFF);
    tx_idle_max = 0;
    rx_idle_max = 0;
    send_hit(16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_hit(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_hit(16'hA5A5, 32'h5A5A_5A5A, 32'h8000_0000, 1'b1);
    send_hit(16'h5A5A, 32'hA5A5_A5A5, 32'h7FFF_FFFF, 1'b1);
  endtask

  // interleaved channels merge into three primitives
  task automatic test_channel_merge();
    write_reference(32'h0000_0000);
    tx_idle_max = IDLE_MAX;
    rx_idle_max = IDLE_MAX;
    send_hit(16'd1, 32'h0000_00A1, 32'd100,        1'b0);
    send_hit(16'd2, 32'h8000_00B2, 32'd0,          1'b0);
    send_hit(16'd3, 32'h0000_00A1, 32'hFFFF_FFFF,  1'b0);
    send_hit(16'd4, 32'hC3C3_C3C3, 32'd50,         1'b0);
    send_hit(16'd5, 32'h8000_00B2, 32'd7,          1'b0);
    send_hit(16'd6, 32'h0000_00A1, 32'd3,          1'b0);
    send_hit(16'd7, 32'hC3C3_C3C3, 32'hFFFF_0000,  1'b0);
    send_hit(16'd8, 32'h8000_00B2, 32'd400,        1'b1);
  endtask

  // tick rounding on both sides of a 25 ns step, largest time difference
  task automatic test_tick_steps();
    write_reference(32'hFFFF_FFFE);
    tx_idle_max = 0;
    rx_idle_max = IDLE_MAX;
    send_hit(16'd10, 32'd1, 32'd1000,       1'b0);
    send_hit(16'd11, 32'd2, 32'd1399,       1'b0);
    send_hit(16'd12, 32'd3, 32'd1400,       1'b0);
    send_hit(16'd13, 32'd4, 32'd1799,       1'b0);
    send_hit(16'd14, 32'd5, 32'd1800,       1'b0);
    send_hit(16'd15, 32'd6, 32'hFFFF_FFFF,  1'b1);
    send_hit(16'd16, 32'd7, 32'd0,          1'b0);
    send_hit(16'd17, 32'd8, 32'hFFFF_FFFF,  1'b1);
  endtask

  // full store: hits past the limit are dropped, last one included
  task automatic test_full_store();
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] base;
    write_reference($urandom);
    pick_idling();
    // every hit on one channel, multiplicity equal to the store depth
    chan = $urandom;
    base = $urandom_range(1000, 32'h7FFF_FFFF);
    for (int n = 0; n < MAX_HITS; n++)
      send_hit(16'($urandom), chan, base + $urandom_range(0, 5000), n == MAX_HITS - 1);
    // the last hit lands on a full store and is dropped, merge still runs
    for (int n = 0; n < MAX_HITS; n++)
      send_hit(16'($urandom), 32'($urandom_range(0, 3)), base + $urandom_range(0, 5000),
               1'b0);
    send_hit(16'hFFFF, 32'hDEAD_0001, 32'd0, 1'b1);
    // dropped hits carry an earlier time and a new channel; neither may count
    pick_idling();
    for (int n = 0; n < MAX_HITS; n++)
      send_hit(16'($urandom), 32'($urandom_range(10, 15)), base + $urandom_range(0, 900),
               1'b0);
    send_hit(16'h0001, 32'hDEAD_0002, 32'd0, 1'b0);
    send_hit(16'h0002, 32'hDEAD_0003, 32'd1, 1'b1);
  endtask

  task automatic test_random_bursts();
    int r;
    int len;
    while (hits_sent < ITEM_TARGET) begin
      write_reference($urandom);
      pick_idling();
      repeat ($urandom_range(2, 5)) begin
        r = $urandom_range(0, 15);
        if (r == 0) len = $urandom_range(MAX_HITS + 1, MAX_HITS + 4);
        else if (r < 5) len = $urandom_range(1, 3);
        else len = $urandom_range(4, MAX_HITS);
        random_burst(len);
      end
    end
  endtask

  // receiver: random stall before each primitive transfer
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, rx_idle_max);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // monitor: compare each primitive transfer with the oldest prediction
  always @(posedge clk) begin
    prim_result_t exp_prim;
    if (!rst && out_valid && out_ready) begin
      if (pending_prims.size() == 0) begin
        report_mismatch($sformatf("unexpected primitive on channel %h", prim_channel));
      end else begin
        exp_prim = pending_prims.pop_front();
        prims_checked++;
        if (prim_hit_number !== exp_prim.prim.id)
          report_mismatch($sformatf("prim_hit_number got %h want %h",
                                    prim_hit_number, exp_prim.prim.id));
        if (prim_channel !== exp_prim.prim.chan)
          report_mismatch($sformatf("prim_channel got %h want %h",
                                    prim_channel, exp_prim.prim.chan));
        if (prim_tick !== exp_prim.prim.tick)
          report_mismatch($sformatf("prim_tick got %h want %h (channel %h)",
                                    prim_tick, exp_prim.prim.tick, exp_prim.prim.chan));
        if (multiplicity !== exp_prim.prim.mult)
          report_mismatch($sformatf("multiplicity got %0d want %0d (channel %h)",
                                    multiplicity, exp_prim.prim.mult, exp_prim.prim.chan));
        if (last_prim !== exp_prim.last)
          report_mismatch($sformatf("last_prim got %b want %b", last_prim, exp_prim.last));
      end
    end
  end

  // watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("timeout with %0d primitives outstanding", pending_prims.size());
    $display("CHECK FAILED");
    $finish;
  end

  // main sequence
  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    hit_number       = '0;
    channel_key      = '0;
    start_time       = '0;
    last_hit         = 1'b0;
    tick_reference   = '0;
    burst_count      = 0;
    earliest_start   = '1;
    errors           = 0;
    hits_sent        = 0;
    bursts_sent      = 0;
    prims_checked    = 0;
    reference_writes = 0;
    tx_idle_max      = 0;
    rx_idle_max      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_hits();
    test_channel_merge();
    test_tick_steps();
    test_full_store();
    test_random_bursts();
    wait_idle();

    if (pending_prims.size() != 0)
      report_mismatch($sformatf("%0d primitives never arrived", pending_prims.size()));
    $display("sent %0d hits in %0d bursts, checked %0d primitives",
             hits_sent, bursts_sent, prims_checked);
    $display("tick reference written %0d times, wrap and full store included",
             reference_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
